/* rtl/embc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extruder motor backoff controller package
// Payload types, function and phase codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package embc_pkg;

  typedef enum logic [2:0] {
    FUNC_TICK      = 3'd0,
    FUNC_SET_SPEED = 3'd1,
    FUNC_SET_RPM   = 3'd2,
    FUNC_TOG_PAUSE = 3'd3,
    FUNC_SET_DIR   = 3'd4,
    FUNC_SET_ON    = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    PH_INACTIVE = 3'd0,
    PH_HALT1    = 3'd1,
    PH_REVERSE  = 3'd2,
    PH_HALT2    = 3'd3,
    PH_FORWARD  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    CFG_BACKOFF_EN   = 3'd0,
    CFG_HALT_TIME    = 3'd1,
    CFG_REVERSE_TIME = 3'd2,
    CFG_FORWARD_TIME = 3'd3,
    CFG_TRIGGER_TIME = 3'd4,
    CFG_EXT_STEPPER  = 3'd5
  } cfg_idx_e;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [15:0] HALT_TIME_RST    = 16'd5;
  localparam logic [15:0] REVERSE_TIME_RST = 16'd500;
  localparam logic [15:0] FORWARD_TIME_RST = 16'd300;
  localparam logic [15:0] TRIGGER_TIME_RST = 16'd300;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [15:0] speed_value;
    logic [31:0]        rpm_value;
    logic               flag;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] drive_speed;
    logic [31:0]        rpm_out;
    logic               rpm_mode;
    logic               rpm_direction;
    logic               motor_enable;
    logic [2:0]         backoff_phase;
  } out_item_t;

  typedef struct packed {
    logic tick;
    logic load;
  } timer_ctrl_t;

endpackage

/* rtl/extruder_motor_backoff_controller_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extruder motor backoff controller
// Keeps commanded speed, rpm and mode; latches a drive on each ms tick and
// runs the halt / reverse / halt / forward backoff after a forward run.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake                  | Payload
//  in      | to block  | in_valid_i / in_stall_o    | in_data_i  (in_item_t)
//  out     | from block| out_valid_o / out_stall_i  | out_data_o (out_item_t)
//  cfg     | to block  | cfg_we_i                   | cfg_index_i, cfg_wdata_i
//
//  One item per cycle while the output does not stall: every item is decoded
//  and its state update and drive latch are computed in one pass from the state
//  registers into the result register, valid in the cycle after the transfer in.
//  The result register takes a new item in the cycle its old result leaves,
//  so input stalls only while a held result is stalled downstream.
//  Reset clears the state registers (not the result payload) and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module extruder_motor_backoff_controller_top #(
  parameter int unsigned TIME_WIDTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  embc_pkg::in_item_t                    in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output embc_pkg::out_item_t                   out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [embc_pkg::CfgIdxWidth-1:0]      cfg_index_i,
  input  logic [embc_pkg::CfgDataWidth-1:0]     cfg_wdata_i
);

  localparam logic [32:0] TimeMax = (33'd1 << TIME_WIDTH) - 33'd1;

  function automatic logic [TIME_WIDTH-1:0] time_load(input logic [15:0] v);
    logic [32:0] w;
    w = {17'd0, v};
    if (w > TimeMax) begin
      w = TimeMax;
    end
    return w[TIME_WIDTH-1:0];
  endfunction

  function automatic logic [15:0] neg16(input logic [15:0] v);
    return (v == 16'h8000) ? 16'h7FFF : (16'd0 - v);
  endfunction

  // configuration
  logic        backoff_en_q, ext_stepper_q;
  logic [15:0] halt_time_q, reverse_time_q, forward_time_q, trigger_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backoff_en_q   <= 1'b0;
      halt_time_q    <= embc_pkg::HALT_TIME_RST;
      reverse_time_q <= embc_pkg::REVERSE_TIME_RST;
      forward_time_q <= embc_pkg::FORWARD_TIME_RST;
      trigger_time_q <= embc_pkg::TRIGGER_TIME_RST;
      ext_stepper_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (embc_pkg::cfg_idx_e'(cfg_index_i))
        embc_pkg::CFG_BACKOFF_EN:   backoff_en_q   <= cfg_wdata_i[0];
        embc_pkg::CFG_HALT_TIME:    halt_time_q    <= cfg_wdata_i;
        embc_pkg::CFG_REVERSE_TIME: reverse_time_q <= cfg_wdata_i;
        embc_pkg::CFG_FORWARD_TIME: forward_time_q <= cfg_wdata_i;
        embc_pkg::CFG_TRIGGER_TIME: trigger_time_q <= cfg_wdata_i;
        embc_pkg::CFG_EXT_STEPPER:  ext_stepper_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // handshake
  logic      out_valid_q;
  logic      in_fire;
  embc_pkg::out_item_t out_q, out_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  // state
  embc_pkg::phase_e phase_q, phase_d;
  logic        trig_started_q, trig_started_d;
  logic [15:0] set_speed_q, set_speed_d;
  logic [31:0] set_rpm_q, set_rpm_d;
  logic        dir_q, dir_d, paused_q, paused_d, on_q, on_d, rpm_q, rpm_d;
  logic [15:0] drv_speed_q, drv_speed_d;
  logic [31:0] drv_rpm_q, drv_rpm_d;
  logic        drv_mode_q, drv_mode_d, drv_dir_q, drv_dir_d, drv_en_q, drv_en_d;

  embc_pkg::timer_ctrl_t pt_ctrl, tt_ctrl;
  logic [TIME_WIDTH-1:0] pt_load_val, pt_count, pt_dec;
  logic [TIME_WIDTH-1:0] tt_count, tt_dec;
  logic                  active, elapsed;

  embc_timer #(
    .WIDTH(TIME_WIDTH)
  ) u_phase_timer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (pt_ctrl),
    .load_val_i(pt_load_val),
    .count_o   (pt_count),
    .dec_o     (pt_dec)
  );

  embc_timer #(
    .WIDTH(TIME_WIDTH)
  ) u_trigger_timer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (tt_ctrl),
    .load_val_i(time_load(trigger_time_q)),
    .count_o   (tt_count),
    .dec_o     (tt_dec)
  );

  assign active  = !paused_q && on_q;
  assign elapsed = trig_started_q && (tt_count == '0);

  always_comb begin
    phase_d        = phase_q;
    trig_started_d = trig_started_q;
    set_speed_d    = set_speed_q;
    set_rpm_d      = set_rpm_q;
    dir_d          = dir_q;
    paused_d       = paused_q;
    on_d           = on_q;
    rpm_d          = rpm_q;
    drv_speed_d    = drv_speed_q;
    drv_rpm_d      = drv_rpm_q;
    drv_mode_d     = drv_mode_q;
    drv_dir_d      = drv_dir_q;
    drv_en_d       = drv_en_q;
    pt_ctrl        = '0;
    tt_ctrl        = '0;
    pt_load_val    = time_load(halt_time_q);

    if (in_fire) begin
      unique case (embc_pkg::func_e'(in_data_i.func))
        embc_pkg::FUNC_TICK: begin
          pt_ctrl.tick = 1'b1;
          tt_ctrl.tick = 1'b1;
          if (backoff_en_q && phase_q != embc_pkg::PH_INACTIVE) begin
            if (pt_dec == '0) begin
              drv_mode_d = 1'b0;
              unique case (phase_q)
                embc_pkg::PH_HALT1: begin
                  phase_d      = embc_pkg::PH_REVERSE;
                  pt_ctrl.load = 1'b1;
                  pt_load_val  = time_load(reverse_time_q);
                  drv_speed_d  = neg16(set_speed_q);
                end
                embc_pkg::PH_REVERSE: begin
                  phase_d      = embc_pkg::PH_HALT2;
                  pt_ctrl.load = 1'b1;
                  pt_load_val  = time_load(halt_time_q);
                  drv_speed_d  = '0;
                end
                embc_pkg::PH_HALT2: begin
                  phase_d      = embc_pkg::PH_FORWARD;
                  pt_ctrl.load = 1'b1;
                  pt_load_val  = time_load(forward_time_q);
                  drv_speed_d  = set_speed_q;
                end
                default: begin
                  phase_d     = embc_pkg::PH_INACTIVE;
                  drv_speed_d = '0;
                end
              endcase
            end
          end else if (!rpm_q) begin
            drv_mode_d  = 1'b0;
            drv_speed_d = active ? (dir_q ? set_speed_q : neg16(set_speed_q)) : '0;
          end else begin
            drv_mode_d = 1'b1;
            drv_dir_d  = dir_q;
            if (ext_stepper_q) begin
              drv_rpm_d = set_rpm_q;
              drv_en_d  = active;
            end else begin
              drv_rpm_d = active ? set_rpm_q : '0;
            end
          end
        end
        embc_pkg::FUNC_SET_SPEED: begin
          set_speed_d = in_data_i.speed_value;
          rpm_d       = 1'b0;
        end
        embc_pkg::FUNC_SET_RPM: begin
          set_rpm_d = in_data_i.rpm_value;
          rpm_d     = 1'b1;
        end
        embc_pkg::FUNC_TOG_PAUSE: paused_d = !paused_q;
        embc_pkg::FUNC_SET_DIR:   dir_d    = in_data_i.flag;
        embc_pkg::FUNC_SET_ON: begin
          // switching off after a long forward run starts backoff when backoff is enabled
          if (!in_data_i.flag && on_q && dir_q && backoff_en_q && elapsed) begin
            phase_d      = embc_pkg::PH_HALT1;
            pt_ctrl.load = 1'b1;
            pt_load_val  = time_load(halt_time_q);
            drv_speed_d  = '0;
            drv_mode_d   = 1'b0;
          end else if (in_data_i.flag) begin
            if (!on_q && dir_q) begin
              tt_ctrl.load   = 1'b1;
              trig_started_d = 1'b1;
            end
            phase_d = embc_pkg::PH_INACTIVE;
          end
          on_d = in_data_i.flag;
        end
        default: ;
      endcase
    end

    out_d.drive_speed   = drv_speed_d;
    out_d.rpm_out       = drv_rpm_d;
    out_d.rpm_mode      = drv_mode_d;
    out_d.rpm_direction = drv_dir_d;
    out_d.motor_enable  = drv_en_d;
    out_d.backoff_phase = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= embc_pkg::PH_INACTIVE;
      trig_started_q <= 1'b0;
      set_speed_q    <= '0;
      set_rpm_q      <= '0;
      dir_q          <= 1'b1;
      paused_q       <= 1'b0;
      on_q           <= 1'b0;
      rpm_q          <= 1'b0;
      drv_speed_q    <= '0;
      drv_rpm_q      <= '0;
      drv_mode_q     <= 1'b0;
      drv_dir_q      <= 1'b0;
      drv_en_q       <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      phase_q        <= phase_d;
      trig_started_q <= trig_started_d;
      set_speed_q    <= set_speed_d;
      set_rpm_q      <= set_rpm_d;
      dir_q          <= dir_d;
      paused_q       <= paused_d;
      on_q           <= on_d;
      rpm_q          <= rpm_d;
      drv_speed_q    <= drv_speed_d;
      drv_rpm_q      <= drv_rpm_d;
      drv_mode_q     <= drv_mode_d;
      drv_dir_q      <= drv_dir_d;
      drv_en_q       <= drv_en_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload; hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // every transfer in yields a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_fire |=> out_valid_q)
    else $error("accepted item produced no result");

  // switching on cancels any backoff
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.func == embc_pkg::FUNC_SET_ON && in_data_i.flag
    |=> phase_q == embc_pkg::PH_INACTIVE)
    else $error("backoff not cancelled by switch on");

  // entering the first halt latches a zero speed drive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && phase_q == embc_pkg::PH_INACTIVE && phase_d == embc_pkg::PH_HALT1
    |=> out_q.drive_speed == '0 && !out_q.rpm_mode
        && out_q.backoff_phase == embc_pkg::PH_HALT1)
    else $error("first halt did not drive zero");

  // trigger timer once started stays started
  assert property (@(posedge clk_i) disable iff (!rst_ni) trig_started_q |=> trig_started_q)
    else $error("trigger started flag dropped");

  // hold the phase timer while no item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> pt_count == $past(pt_count))
    else $error("phase timer moved without a transfer");

  // a tick steps the trigger timer down, stopping at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.func == embc_pkg::FUNC_TICK |=> tt_count == $past(tt_dec))
    else $error("trigger timer did not advance on tick");

endmodule

/* rtl/embc_timer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Millisecond down-counter
// Loadable timer that steps down once per tick and holds at zero.
// ----------------------------------------------------------------------------
module embc_timer #(
  parameter int unsigned WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  embc_pkg::timer_ctrl_t ctrl_i,
  input  logic [WIDTH-1:0]     load_val_i,
  output logic [WIDTH-1:0]     count_o,
  output logic [WIDTH-1:0]     dec_o
);

  logic [WIDTH-1:0] count_q, count_d;

  // value after this tick's decrement, saturating at zero
  assign dec_o = (count_q != '0) ? (count_q - WIDTH'(1)) : count_q;

  always_comb begin
    count_d = count_q;
    if (ctrl_i.load) begin
      count_d = load_val_i;
    end else if (ctrl_i.tick) begin
      count_d = dec_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule
